### sv/assert_macros.svh
// Assertion macros shared by the sample standard deviation RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition never holds outside reset.
`define SSD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

### sv/ssd_pkg.sv
// Package for the sample standard deviation block: constants, types and width helpers.
`default_nettype none

package ssd_pkg;

  // Default sample limit per run
  localparam int MAX_SAMPLES_DEF = 4096;

  // Fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int STD_W    = 24;
  localparam int STATUS_W = 2;

  // Variance is scaled by 2^16 so the root carries 8 fraction bits
  localparam int FRAC_SHIFT = 16;

  // Scaled variance stays below 2^47 for 16-bit samples; even width for the root
  localparam int QUO_W = 48;

  // Depth of the queue of finished runs between front and back
  localparam int FIFO_DEPTH = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_LIMIT = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_SUB,
    BK_DIV,
    BK_SQRT,
    BK_DONE
  } back_state_e;

  // Bits needed to count up to the sample limit itself
  function automatic int cnt_width(input int max_samples);
    return $clog2(max_samples + 1);
  endfunction

  // Signed running sum
  function automatic int sum_width(input int cnt_w);
    return SAMPLE_W + cnt_w;
  endfunction

  // Unsigned running sum of squares; one square is at most 2^30
  function automatic int ssq_width(input int cnt_w);
    return 2 * SAMPLE_W - 2 + cnt_w;
  endfunction

  // Packed run record: status, count, sum, sum of squares
  function automatic int job_width(input int cnt_w);
    return STATUS_W + cnt_w + sum_width(cnt_w) + ssq_width(cnt_w);
  endfunction

endpackage

`default_nettype wire

### sv/ssd_if.sv
// Stream interfaces for the sample input and the result output.
`default_nettype none

interface ssd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ssd_pkg::SAMPLE_W-1:0] sample;
  logic                                last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface ssd_out_if;
  logic                         valid;
  logic                         ready;
  logic [ssd_pkg::STD_W-1:0]    std_dev;
  logic [ssd_pkg::STATUS_W-1:0] status;

  modport source (output valid, output std_dev, output status, input ready);
  modport sink   (input valid, input std_dev, input status, output ready);
endinterface

`default_nettype wire

### sv/ssd_fifo.sv
// Small register queue that carries finished run records from front to back.
`default_nettype none
`include "assert_macros.svh"

module ssd_fifo #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 2,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  output logic [WIDTH-1:0] rd_data_o,
  input  logic             rd_ready_i,
  output logic [CNT_W-1:0] count_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_pop;

  assign do_pop     = rd_ready_i && (count_q != '0);
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign count_o    = count_q;

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_valid_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({wr_valid_i, do_pop})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (wr_valid_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  `SSD_ASSERT(a_no_write_when_full, wr_valid_i |-> (count_q < CNT_W'(DEPTH)), "queue write while full")
  `SSD_ASSERT_NEVER(a_count_range, count_q > CNT_W'(DEPTH), "queue occupancy beyond depth")

endmodule

`default_nettype wire

### sv/ssd_front.sv
// Front end: takes samples, squares them and accumulates count, sum and sum of squares.
`default_nettype none
`include "assert_macros.svh"

module ssd_front #(
  parameter  int MAX_SAMPLES = ssd_pkg::MAX_SAMPLES_DEF,
  localparam int JOB_W = ssd_pkg::job_width(ssd_pkg::cnt_width(MAX_SAMPLES)),
  localparam int FC_W  = $clog2(ssd_pkg::FIFO_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ssd_in_if.sink            in_i,
  input  logic [FC_W-1:0]   fifo_count_i,
  output logic              job_valid_o,
  output logic [JOB_W-1:0]  job_data_o
);

  import ssd_pkg::*;

  localparam int CNT_W = cnt_width(MAX_SAMPLES);
  localparam int SUM_W = sum_width(CNT_W);
  localparam int SSQ_W = ssq_width(CNT_W);
  localparam int SQR_W = 2 * SAMPLE_W - 1;

  // Square stage
  logic                       p_valid_q;
  logic                       p_last_q;
  logic signed [SAMPLE_W-1:0] p_sample_q;
  logic [SQR_W-1:0]           p_square_q;
  logic signed [2*SAMPLE_W-1:0] square_full;

  // Accumulators
  logic [CNT_W-1:0]        cnt_q, cnt_acc;
  logic signed [SUM_W-1:0] sum_q, sum_acc;
  logic [SSQ_W-1:0]        ssq_q, ssq_acc;
  logic                    ovf_q, ovf_acc;
  logic                    under_limit;
  logic                    accept;
  logic                    pend_push;
  logic [FC_W:0]           occupancy;
  status_e                 run_status;

  // Room in the queue also for a record still in the square stage
  assign pend_push = p_valid_q && p_last_q;
  assign occupancy = {1'b0, fifo_count_i} + {{FC_W{1'b0}}, pend_push};
  assign in_i.ready = (occupancy < (FC_W + 1)'(FIFO_DEPTH));
  assign accept = in_i.valid && in_i.ready;

  assign square_full = in_i.sample * in_i.sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      p_last_q  <= 1'b0;
    end else begin
      p_valid_q <= accept;
      p_last_q  <= in_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_sample_q <= in_i.sample;
      p_square_q <= square_full[SQR_W-1:0];
    end
  end

  // Accumulate while under the limit, else flag the overrun
  always_comb begin
    under_limit = (cnt_q < CNT_W'(MAX_SAMPLES));
    cnt_acc = cnt_q;
    sum_acc = sum_q;
    ssq_acc = ssq_q;
    ovf_acc = ovf_q;
    if (under_limit) begin
      cnt_acc = cnt_q + CNT_W'(1);
      sum_acc = sum_q + {{(SUM_W - SAMPLE_W){p_sample_q[SAMPLE_W-1]}}, p_sample_q};
      ssq_acc = ssq_q + {{(SSQ_W - SQR_W){1'b0}}, p_square_q};
    end else begin
      ovf_acc = 1'b1;
    end
  end

  // Limit overrun is checked before the short run
  always_comb begin
    if (ovf_acc) begin
      run_status = ST_LIMIT;
    end else if (cnt_acc < CNT_W'(2)) begin
      run_status = ST_SHORT;
    end else begin
      run_status = ST_OK;
    end
  end

  assign job_valid_o = pend_push;
  assign job_data_o  = {run_status, cnt_acc, sum_acc, ssq_acc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
      ssq_q <= '0;
      ovf_q <= 1'b0;
    end else if (p_valid_q) begin
      if (p_last_q) begin
        cnt_q <= '0;
        sum_q <= '0;
        ssq_q <= '0;
        ovf_q <= 1'b0;
      end else begin
        cnt_q <= cnt_acc;
        sum_q <= sum_acc;
        ssq_q <= ssq_acc;
        ovf_q <= ovf_acc;
      end
    end
  end

  `SSD_ASSERT(a_clear_after_last, pend_push |=> (cnt_q == '0) && !ovf_q, "run state not cleared after last sample")
  `SSD_ASSERT_NEVER(a_count_limit, cnt_q > CNT_W'(MAX_SAMPLES), "sample count beyond limit")

endmodule

`default_nettype wire

### sv/ssd_back.sv
// Back end: variance by shift-add multiply and long division, then integer square root.
`default_nettype none
`include "assert_macros.svh"

module ssd_back #(
  parameter  int MAX_SAMPLES = ssd_pkg::MAX_SAMPLES_DEF,
  localparam int JOB_W = ssd_pkg::job_width(ssd_pkg::cnt_width(MAX_SAMPLES))
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  logic [JOB_W-1:0] job_data_i,
  output logic             job_pop_o,
  ssd_out_if.source        out_o
);

  import ssd_pkg::*;

  localparam int CNT_W  = cnt_width(MAX_SAMPLES);
  localparam int SUM_W  = sum_width(CNT_W);
  localparam int SSQ_W  = ssq_width(CNT_W);
  localparam int MAG_W  = SUM_W - 1;
  localparam int PROD_W = 2 * MAG_W;
  localparam int M_W    = 2 * CNT_W;
  localparam int DIV_W  = PROD_W + FRAC_SHIFT;
  localparam int STEP_W = $clog2(DIV_W);

  // Record fields
  logic [STATUS_W-1:0]     job_status_raw;
  status_e                 job_status;
  logic [CNT_W-1:0]        job_n;
  logic signed [SUM_W-1:0] job_sum;
  logic [SSQ_W-1:0]        job_ssq;
  logic [SUM_W-1:0]        sum_abs;
  logic [MAG_W-1:0]        job_mag;

  assign {job_status_raw, job_n, job_sum, job_ssq} = job_data_i;
  assign job_status = status_e'(job_status_raw);
  assign sum_abs = job_sum[SUM_W-1] ? SUM_W'(-job_sum) : SUM_W'(job_sum);
  assign job_mag = sum_abs[MAG_W-1:0];

  back_state_e state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  // Multiply phase: n*sumsq, |sum|^2 and n*(n-1) side by side
  logic [PROD_W-1:0] a_acc_q, a_acc_d, a_mcand_q, a_mcand_d;
  logic [PROD_W-1:0] b_acc_q, b_acc_d, b_mcand_q, b_mcand_d;
  logic [MAG_W-1:0]  b_mplier_q, b_mplier_d;
  logic [CNT_W-1:0]  n_mplier_q, n_mplier_d;
  logic [M_W-1:0]    m_acc_q, m_acc_d, m_mcand_q, m_mcand_d;

  // Division and root
  logic [DIV_W-1:0]  div_q, div_d;
  logic [M_W-1:0]    rem_q, rem_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [QUO_W-1:0]  res_q, res_d;
  logic [QUO_W-1:0]  bit_q, bit_d;
  logic [STD_W-1:0]  std_q, std_d;
  status_e           status_q, status_d;

  logic [PROD_W-1:0] diff;
  logic [M_W:0]      rem_sh;
  logic [M_W:0]      rem_sub;
  logic              div_ge;
  logic [QUO_W-1:0]  trial;

  assign diff    = (a_acc_q >= b_acc_q) ? a_acc_q - b_acc_q : '0;
  assign rem_sh  = {rem_q, div_q[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, m_acc_q};
  assign div_ge  = (rem_sh >= {1'b0, m_acc_q});
  assign trial   = res_q + bit_q;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    a_acc_d    = a_acc_q;
    a_mcand_d  = a_mcand_q;
    b_acc_d    = b_acc_q;
    b_mcand_d  = b_mcand_q;
    b_mplier_d = b_mplier_q;
    n_mplier_d = n_mplier_q;
    m_acc_d    = m_acc_q;
    m_mcand_d  = m_mcand_q;
    div_d      = div_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    res_d      = res_q;
    bit_d      = bit_q;
    std_d      = std_q;
    status_d   = status_q;
    job_pop_o  = 1'b0;

    unique case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          job_pop_o  = 1'b1;
          n_mplier_d = job_n;
          a_acc_d    = '0;
          a_mcand_d  = PROD_W'(job_ssq);
          b_acc_d    = '0;
          b_mcand_d  = PROD_W'(job_mag);
          b_mplier_d = job_mag;
          m_acc_d    = '0;
          m_mcand_d  = M_W'(job_n - CNT_W'(1));
          step_d     = STEP_W'(MAG_W - 1);
          if (job_status == ST_OK) begin
            state_d = BK_MUL;
          end else begin
            std_d    = '0;
            status_d = job_status;
            state_d  = BK_DONE;
          end
        end
      end
      BK_MUL: begin
        if (n_mplier_q[0]) begin
          a_acc_d = a_acc_q + a_mcand_q;
          m_acc_d = m_acc_q + m_mcand_q;
        end
        if (b_mplier_q[0]) begin
          b_acc_d = b_acc_q + b_mcand_q;
        end
        a_mcand_d  = a_mcand_q << 1;
        b_mcand_d  = b_mcand_q << 1;
        m_mcand_d  = m_mcand_q << 1;
        n_mplier_d = n_mplier_q >> 1;
        b_mplier_d = b_mplier_q >> 1;
        step_d     = step_q - STEP_W'(1);
        if (step_q == '0) begin
          state_d = BK_SUB;
        end
      end
      BK_SUB: begin
        div_d   = {diff, {FRAC_SHIFT{1'b0}}};
        rem_d   = '0;
        quo_d   = '0;
        step_d  = STEP_W'(DIV_W - 1);
        state_d = BK_DIV;
      end
      BK_DIV: begin
        // One quotient bit per cycle; the quotient then feeds the root in place
        rem_d  = div_ge ? rem_sub[M_W-1:0] : rem_sh[M_W-1:0];
        div_d  = div_q << 1;
        quo_d  = {quo_q[QUO_W-2:0], div_ge};
        step_d = step_q - STEP_W'(1);
        if (step_q == '0) begin
          res_d   = '0;
          bit_d   = QUO_W'(1) << (QUO_W - 2);
          step_d  = STEP_W'(QUO_W / 2 - 1);
          state_d = BK_SQRT;
        end
      end
      BK_SQRT: begin
        // Two radicand bits per cycle
        if (quo_q >= trial) begin
          quo_d = quo_q - trial;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d  = bit_q >> 2;
        step_d = step_q - STEP_W'(1);
        if (step_q == '0) begin
          status_d = ST_OK;
          if (|res_d[QUO_W-1:STD_W]) begin
            std_d = '1;
          end else begin
            std_d = res_d[STD_W-1:0];
          end
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_o.ready) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q     <= step_d;
    a_acc_q    <= a_acc_d;
    a_mcand_q  <= a_mcand_d;
    b_acc_q    <= b_acc_d;
    b_mcand_q  <= b_mcand_d;
    b_mplier_q <= b_mplier_d;
    n_mplier_q <= n_mplier_d;
    m_acc_q    <= m_acc_d;
    m_mcand_q  <= m_mcand_d;
    div_q      <= div_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    res_q      <= res_d;
    bit_q      <= bit_d;
    std_q      <= std_d;
    status_q   <= status_d;
  end

  assign out_o.valid   = (state_q == BK_DONE);
  assign out_o.std_dev = std_q;
  assign out_o.status  = status_q;

  `SSD_ASSERT(a_error_zero, out_o.valid && (out_o.status != ST_OK) |-> (out_o.std_dev == '0), "error result with nonzero deviation")
  `SSD_ASSERT(a_rem_below_divisor, (state_q == BK_DIV) |-> (rem_q < m_acc_q), "division remainder not below divisor")

endmodule

`default_nettype wire

### sv/sample_standard_deviation.sv
// Top level of the sample standard deviation block: front end, run queue and back end.
//
// Samples stream in at one transfer per cycle; the sample flagged last closes a run,
// and for it one result transfer gives floor(sqrt(var * 65536)) (8 fraction bits) with
// status 0, or 0 with status 1 (fewer than two samples) or 2 (more than MAX_SAMPLES
// samples, the extra ones not counted). A closed run goes into a two-entry queue and
// the back end works it out with its bit-serial multiply over MAG_W bits, its
// one-bit-per-cycle division over DIV_W bits and two-bits-per-cycle square root,
// where MAG_W = 15 + clog2(MAX_SAMPLES + 1) and DIV_W = 2 * MAG_W + 16; error runs
// go straight to the result. Input ready drops only while the queue and the
// registered square stage together hold two closed runs; samples keep flowing
// otherwise.
`default_nettype none

module sample_standard_deviation #(
  parameter int MAX_SAMPLES = ssd_pkg::MAX_SAMPLES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ssd_in_if.sink    in_i,
  ssd_out_if.source out_o
);

  import ssd_pkg::*;

  localparam int JOB_W = job_width(cnt_width(MAX_SAMPLES));
  localparam int FC_W  = $clog2(FIFO_DEPTH + 1);

  logic             job_wr_valid;
  logic [JOB_W-1:0] job_wr_data;
  logic             job_rd_valid;
  logic [JOB_W-1:0] job_rd_data;
  logic             job_pop;
  logic [FC_W-1:0]  job_count;

  ssd_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .fifo_count_i (job_count),
    .job_valid_o  (job_wr_valid),
    .job_data_o   (job_wr_data)
  );

  ssd_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (job_wr_valid),
    .wr_data_i  (job_wr_data),
    .rd_valid_o (job_rd_valid),
    .rd_data_o  (job_rd_data),
    .rd_ready_i (job_pop),
    .count_o    (job_count)
  );

  ssd_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_rd_valid),
    .job_data_i  (job_rd_data),
    .job_pop_o   (job_pop),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
